### rtl/core/pressure_sensor_compensation_macros.svh
// Assertion macros for the pressure sensor compensation block.
`ifndef PRESSURE_SENSOR_COMPENSATION_MACROS_SVH
`define PRESSURE_SENSOR_COMPENSATION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("psc assertion failed");

// Next-cycle implication, disabled during reset.
`define PSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("psc assertion failed");

`endif

### rtl/core/psc_pkg.sv
// Types, constants and microcode table for the pressure sensor compensation block.
package psc_pkg;

  localparam int unsigned RawW   = 24;
  localparam int unsigned CfgW   = 40;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned StepW  = 5;
  localparam int unsigned ShiftW = 6;
  localparam int unsigned OpBW   = 34;

  localparam logic [RawW-1:0] RAW_DISABLED = 24'h800000;

  localparam logic [CfgIdxW-1:0] REG_TEMP_TRIM    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PRESS_TRIM_A = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PRESS_TRIM_B = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PRESS_TRIM_C = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_PRESS_TRIM_D = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_PRESS_TRIM_E = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_PRESS_TRIM_F = 3'd6;

  localparam logic [StepW-1:0] STEP_FIRST      = 5'd0;
  localparam logic [StepW-1:0] STEP_TEMP_LAST  = 5'd5;
  localparam logic [StepW-1:0] STEP_PRESS_FIRST = 5'd6;
  localparam logic [StepW-1:0] STEP_LAST       = 5'd25;

  typedef enum logic [3:0] {
    A_D, A_LIN, A_T2, A_T3, A_TMP, A_ACC, A_POLY, A_Q, A_PR, A_PSQ, A_PCU,
    A_P1M, A_P5, A_P9
  } a_sel_e;

  typedef enum logic [4:0] {
    B_T2C, B_D, B_T3C, B_100, B_ONE, B_LIN, B_P6, B_P7, B_P8, B_P2M, B_P3, B_P4,
    B_P10, B_P11, B_PR, B_Q, B_E16, B_E18, B_E20, B_E27
  } b_sel_e;

  typedef enum logic [3:0] {
    D_TMP, D_ACC, D_LIN, D_TOUT, D_T2, D_T3, D_POLY, D_Q, D_PSQ, D_PCU, D_POUT
  } dest_e;

  typedef struct packed {
    a_sel_e              a_sel;
    b_sel_e              b_sel;
    logic [ShiftW-1:0]   shift;
    dest_e               dest;
    logic                add;
  } uop_t;

  function automatic uop_t uop(input a_sel_e a, input b_sel_e b, input int unsigned s,
                               input dest_e d, input logic add);
    uop_t u;
    u.a_sel = a;
    u.b_sel = b;
    u.shift = ShiftW'(s);
    u.dest  = d;
    u.add   = add;
    return u;
  endfunction

  function automatic uop_t ucode(input logic [StepW-1:0] step);
    uop_t u;
    case (step)
      5'd0:    u = uop(A_D,    B_T2C, 0,  D_TMP,  1'b0);
      5'd1:    u = uop(A_TMP,  B_E18, 0,  D_ACC,  1'b0);
      5'd2:    u = uop(A_D,    B_D,   0,  D_TMP,  1'b0);
      5'd3:    u = uop(A_TMP,  B_T3C, 0,  D_ACC,  1'b1);
      5'd4:    u = uop(A_ACC,  B_ONE, 28, D_LIN,  1'b0);
      5'd5:    u = uop(A_LIN,  B_100, 20, D_TOUT, 1'b0);
      5'd6:    u = uop(A_LIN,  B_LIN, 20, D_T2,   1'b0);
      5'd7:    u = uop(A_T2,   B_ONE, 12, D_TMP,  1'b0);
      5'd8:    u = uop(A_TMP,  B_LIN, 8,  D_T3,   1'b0);
      5'd9:    u = uop(A_P5,   B_E27, 0,  D_ACC,  1'b0);
      5'd10:   u = uop(A_LIN,  B_P6,  2,  D_ACC,  1'b1);
      5'd11:   u = uop(A_T2,   B_P7,  4,  D_ACC,  1'b1);
      5'd12:   u = uop(A_T3,   B_P8,  11, D_ACC,  1'b1);
      5'd13:   u = uop(A_P1M,  B_E16, 0,  D_POLY, 1'b0);
      5'd14:   u = uop(A_LIN,  B_P2M, 13, D_POLY, 1'b1);
      5'd15:   u = uop(A_T2,   B_P3,  16, D_POLY, 1'b1);
      5'd16:   u = uop(A_T3,   B_P4,  21, D_POLY, 1'b1);
      5'd17:   u = uop(A_POLY, B_PR,  12, D_ACC,  1'b1);
      5'd18:   u = uop(A_P9,   B_E20, 0,  D_Q,    1'b0);
      5'd19:   u = uop(A_LIN,  B_P10, 0,  D_Q,    1'b1);
      5'd20:   u = uop(A_Q,    B_ONE, 8,  D_Q,    1'b0);
      5'd21:   u = uop(A_PR,   B_PR,  16, D_PSQ,  1'b0);
      5'd22:   u = uop(A_PSQ,  B_PR,  8,  D_PCU,  1'b0);
      5'd23:   u = uop(A_PSQ,  B_Q,   20, D_ACC,  1'b1);
      5'd24:   u = uop(A_PCU,  B_P11, 17, D_ACC,  1'b1);
      5'd25:   u = uop(A_ACC,  B_ONE, 20, D_POUT, 1'b0);
      default: u = uop(A_ACC,  B_ONE, 0,  D_TMP,  1'b0);
    endcase
    return u;
  endfunction

endpackage

### rtl/core/pressure_sensor_compensation.sv
// Top level of the pressure sensor compensation block.
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one word of raw pressure and raw
//   temperature. Output channel: out_valid_o / out_stall_i carry one word of
//   compensated temperature, pressure, channel flags and the clip flag.
//   A word moves at a rising edge with valid high and stall low.
//   Every product goes through one shared 33 x 34 multiplier in two halves, so a
//   microcode step runs through the states low half, high half, round and write back.
//   Both channels enabled: 26 steps. Temperature only: 6 steps. Pressure only:
//   20 steps. Both disabled: no steps, the word goes straight to the done state.
//   in_stall_o stays high while a word is worked on.
//   A finished word waits in the output register; while the receiver stalls
//   and that register is full, the next result holds until it drains.
//   The configuration port writes one trim register per enabled cycle, no wait;
//   write only while the block is idle.
//   Reset clears trim registers, the stored linear temperature and the handshake.
`include "pressure_sensor_compensation_macros.svh"
module pressure_sensor_compensation (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [psc_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [psc_pkg::RawW-1:0]      raw_pressure_i,
  input  logic [psc_pkg::RawW-1:0]      raw_temperature_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [15:0]            temp_centi_deg_o,
  output logic [20:0]                   press_sixteenth_pa_o,
  output logic                          temp_valid_o,
  output logic                          press_valid_o,
  output logic                          clipped_o
);
  import psc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MLO  = 3'd1;
  localparam logic [2:0] ST_MHI  = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_WB   = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [StepW-1:0]    step_q, step_d;
  logic                t_on_q, p_on_q;
  logic                out_valid_q;

  logic [39:0]         temp_trim_q;
  logic [31:0]         trim_a_q, trim_c_q;
  logic [15:0]         trim_b_q, trim_d_q, trim_e_q, trim_f_q;

  logic signed [24:0]  d_q;
  logic [23:0]         pr_q;
  logic signed [31:0]  lin_q;
  logic signed [63:0]  tmp_q, acc_q, tout_q, t2_q, t3_q, poly_q, q_q, psq_q, pcu_q, pout_q;
  logic signed [66:0]  lo_q, hi_q;
  logic signed [63:0]  prod_q;

  logic signed [15:0]  temp_q;
  logic [20:0]         press_q;
  logic                tval_q, pval_q, clip_q;

  uop_t                u;
  logic signed [63:0]  op_a;
  logic signed [OpBW-1:0] op_b;
  logic signed [32:0]  mul_a;
  logic signed [66:0]  mul_p;
  logic signed [63:0]  rnd;
  logic signed [63:0]  res;
  logic signed [63:0]  cur;
  logic signed [63:0]  wb_val;
  logic                in_acc;
  logic                out_free;
  logic                t_on_in, p_on_in;
  logic signed [15:0]  temp_sat;
  logic [20:0]         press_sat;
  logic                t_clip, p_clip;

  assign u        = ucode(step_q);
  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign t_on_in  = raw_temperature_i != RAW_DISABLED;
  assign p_on_in  = raw_pressure_i != RAW_DISABLED;

  always_comb begin
    case (u.a_sel)
      A_D:     op_a = 64'(d_q);
      A_LIN:   op_a = 64'(lin_q);
      A_T2:    op_a = t2_q;
      A_T3:    op_a = t3_q;
      A_TMP:   op_a = tmp_q;
      A_ACC:   op_a = acc_q;
      A_POLY:  op_a = poly_q;
      A_Q:     op_a = q_q;
      A_PR:    op_a = {40'd0, pr_q};
      A_PSQ:   op_a = psq_q;
      A_PCU:   op_a = pcu_q;
      A_P1M:   op_a = 64'($signed(trim_a_q[15:0])) - 64'sd16384;
      A_P5:    op_a = {48'd0, trim_c_q[15:0]};
      A_P9:    op_a = 64'($signed(trim_e_q));
      default: op_a = 64'sd0;
    endcase
  end

  always_comb begin
    case (u.b_sel)
      B_T2C:   op_b = {18'd0, temp_trim_q[31:16]};
      B_D:     op_b = OpBW'(d_q);
      B_T3C:   op_b = OpBW'($signed(temp_trim_q[39:32]));
      B_100:   op_b = 34'sd100;
      B_ONE:   op_b = 34'sd1;
      B_LIN:   op_b = OpBW'(lin_q);
      B_P6:    op_b = {18'd0, trim_c_q[31:16]};
      B_P7:    op_b = OpBW'($signed(trim_d_q[7:0]));
      B_P8:    op_b = OpBW'($signed(trim_d_q[15:8]));
      B_P2M:   op_b = OpBW'($signed(trim_a_q[31:16])) - 34'sd16384;
      B_P3:    op_b = OpBW'($signed(trim_b_q[7:0]));
      B_P4:    op_b = OpBW'($signed(trim_b_q[15:8]));
      B_P10:   op_b = OpBW'($signed(trim_f_q[7:0]));
      B_P11:   op_b = OpBW'($signed(trim_f_q[15:8]));
      B_PR:    op_b = {10'd0, pr_q};
      B_Q:     op_b = q_q[OpBW-1:0];
      B_E16:   op_b = 34'sd65536;
      B_E18:   op_b = 34'sd262144;
      B_E20:   op_b = 34'sd1048576;
      B_E27:   op_b = 34'sd134217728;
      default: op_b = 34'sd0;
    endcase
  end

  assign mul_a = (state_q == ST_MLO) ? {1'b0, op_a[31:0]} : {op_a[63], op_a[63:32]};
  assign mul_p = 67'(mul_a) * 67'(op_b);
  assign rnd   = (u.shift == '0) ? 64'sd0 : (64'sd1 <<< (u.shift - 6'd1));
  assign res   = prod_q >>> u.shift;

  always_comb begin
    case (u.dest)
      D_ACC:   cur = acc_q;
      D_POLY:  cur = poly_q;
      D_Q:     cur = q_q;
      default: cur = 64'sd0;
    endcase
  end
  assign wb_val = u.add ? (cur + res) : res;

  always_comb begin
    t_clip = 1'b0;
    p_clip = 1'b0;
    if (tout_q > 64'sd32767) begin
      temp_sat = 16'sh7fff;
      t_clip   = 1'b1;
    end else if (tout_q < -64'sd32768) begin
      temp_sat = -16'sh8000;
      t_clip   = 1'b1;
    end else begin
      temp_sat = tout_q[15:0];
    end
    if (pout_q > 64'sd2097151) begin
      press_sat = 21'h1fffff;
      p_clip    = 1'b1;
    end else if (pout_q < 64'sd0) begin
      press_sat = 21'd0;
      p_clip    = 1'b1;
    end else begin
      press_sat = pout_q[20:0];
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          step_d  = t_on_in ? STEP_FIRST : STEP_PRESS_FIRST;
          state_d = (t_on_in || p_on_in) ? ST_MLO : ST_DONE;
        end
      end
      ST_MLO:  state_d = ST_MHI;
      ST_MHI:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_WB;
      ST_WB: begin
        if (step_q == STEP_LAST || (step_q == STEP_TEMP_LAST && !p_on_q)) begin
          state_d = ST_DONE;
        end else begin
          step_d  = step_q + 5'd1;
          state_d = ST_MLO;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_FIRST;
      out_valid_q <= 1'b0;
      t_on_q      <= 1'b0;
      p_on_q      <= 1'b0;
      lin_q       <= '0;
      temp_trim_q <= '0;
      trim_a_q    <= '0;
      trim_b_q    <= '0;
      trim_c_q    <= '0;
      trim_d_q    <= '0;
      trim_e_q    <= '0;
      trim_f_q    <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (in_acc) begin
        t_on_q <= t_on_in;
        p_on_q <= p_on_in;
      end
      if (state_q == ST_WB && u.dest == D_LIN) begin
        lin_q <= wb_val[31:0];
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_TEMP_TRIM:    temp_trim_q <= cfg_wdata_i;
          REG_PRESS_TRIM_A: trim_a_q    <= cfg_wdata_i[31:0];
          REG_PRESS_TRIM_B: trim_b_q    <= cfg_wdata_i[15:0];
          REG_PRESS_TRIM_C: trim_c_q    <= cfg_wdata_i[31:0];
          REG_PRESS_TRIM_D: trim_d_q    <= cfg_wdata_i[15:0];
          REG_PRESS_TRIM_E: trim_e_q    <= cfg_wdata_i[15:0];
          REG_PRESS_TRIM_F: trim_f_q    <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      d_q  <= $signed({1'b0, raw_temperature_i}) - $signed({1'b0, temp_trim_q[15:0], 8'd0});
      pr_q <= raw_pressure_i;
    end
    if (state_q == ST_MLO) begin
      lo_q <= mul_p;
    end
    if (state_q == ST_MHI) begin
      hi_q <= mul_p;
    end
    if (state_q == ST_SUM) begin
      prod_q <= lo_q[63:0] + {hi_q[31:0], 32'd0} + rnd;
    end
    if (state_q == ST_WB) begin
      case (u.dest)
        D_TMP:   tmp_q  <= wb_val;
        D_ACC:   acc_q  <= wb_val;
        D_TOUT:  tout_q <= wb_val;
        D_T2:    t2_q   <= wb_val;
        D_T3:    t3_q   <= wb_val;
        D_POLY:  poly_q <= wb_val;
        D_Q:     q_q    <= wb_val;
        D_PSQ:   psq_q  <= wb_val;
        D_PCU:   pcu_q  <= wb_val;
        D_POUT:  pout_q <= wb_val;
        default: ;
      endcase
    end
    if (state_q == ST_DONE && out_free) begin
      temp_q  <= t_on_q ? temp_sat : 16'sd0;
      press_q <= p_on_q ? press_sat : 21'd0;
      tval_q  <= t_on_q;
      pval_q  <= p_on_q;
      clip_q  <= (t_on_q && t_clip) || (p_on_q && p_clip);
    end
  end

  assign in_stall_o           = state_q != ST_IDLE;
  assign out_valid_o          = out_valid_q;
  assign temp_centi_deg_o     = temp_q;
  assign press_sixteenth_pa_o = press_q;
  assign temp_valid_o         = tval_q;
  assign press_valid_o        = pval_q;
  assign clipped_o            = clip_q;

  `PSC_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `PSC_ASSERT_IMP(a_step_range, clk_i, rst_ni, state_q != ST_IDLE, step_q <= STEP_LAST)
  `PSC_ASSERT_IMP(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == ST_DONE))
  `PSC_ASSERT_IMP(a_skip_temp, clk_i, rst_ni, state_q == ST_MLO && !t_on_q,
                  step_q >= STEP_PRESS_FIRST)

endmodule
